>>> rtl/ogdpc_pkg.sv
// shared types and constants of the occupancy grid disc paint and check block
package ogdpc_pkg;

	// grid geometry and disc bound
	localparam int GridCols = 128;
	localparam int GridRows = 128;
	localparam int MaxRad = 15;
	localparam int GridDepth = GridCols * GridRows;
	localparam int AddrW = $clog2(GridDepth);

	// field widths fixed by the interface
	localparam int OpW = 3;
	localparam int InCoordW = 9;
	localparam int ByteW = 8;
	localparam int RsqW = 8;
	localparam int CfgIdxW = 2;

	// internal widths
	localparam int OffW = $clog2(MaxRad + 1) + 1;
	localparam int CoordW = InCoordW + 1;
	localparam int DistW = 2 * OffW + 1;

	// a cell at or above this value counts as occupied
	localparam logic [ByteW-1:0] OccThreshold = ByteW'(50);
	localparam logic [RsqW-1:0] RsqMax = RsqW'(MaxRad * MaxRad);

	// operation codes
	typedef enum logic [OpW-1:0] {
		OpWrite = 3'd0,
		OpRead = 3'd1,
		OpPaintOcc = 3'd2,
		OpPaintFree = 3'd3,
		OpQuery = 3'd4,
		OpClear = 3'd5
	} op_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CfgCols = 2'd0,
		CfgRows = 2'd1,
		CfgFree = 2'd2,
		CfgOcc = 2'd3
	} cfg_idx_t;

	// what the disc unit reports for one offset
	typedef struct packed {
		logic in_disc;
		logic in_map;
		logic [AddrW-1:0] addr;
	} cell_chk_t;

endpackage

>>> rtl/ogdpc_disc_unit.sv
// shared disc unit: distance test, map bounds and cell address for one offset
module ogdpc_disc_unit import ogdpc_pkg::*; (
	input logic signed [InCoordW-1:0] cx,
	input logic signed [InCoordW-1:0] cy,
	input logic signed [OffW-1:0] dx,
	input logic signed [OffW-1:0] dy,
	input logic [RsqW-1:0] rsq,
	input logic [ByteW-1:0] cols,
	input logic [ByteW-1:0] rows,
	output cell_chk_t chk
);

	logic signed [CoordW-1:0] x;
	logic signed [CoordW-1:0] y;
	logic [CoordW-1:0] w;
	logic [CoordW-1:0] h;
	logic signed [2*OffW-1:0] dxx;
	logic signed [2*OffW-1:0] dyy;
	logic [DistW-1:0] sq_dist;

	// cell position
	assign x = CoordW'(cx) + CoordW'(dx);
	assign y = CoordW'(cy) + CoordW'(dy);

	// map size clamped to the grid
	assign w = (CoordW'(cols) < CoordW'(GridCols)) ? CoordW'(cols) : CoordW'(GridCols);
	assign h = (CoordW'(rows) < CoordW'(GridRows)) ? CoordW'(rows) : CoordW'(GridRows);

	// squared distance from the centre
	assign dxx = (2*OffW)'(dx) * (2*OffW)'(dx);
	assign dyy = (2*OffW)'(dy) * (2*OffW)'(dy);
	assign sq_dist = DistW'(unsigned'(dxx)) + DistW'(unsigned'(dyy));

	always_comb begin
		chk.in_disc = sq_dist <= DistW'(rsq);
		chk.in_map = !x[CoordW-1] && !y[CoordW-1] &&
			(unsigned'(x) < w) && (unsigned'(y) < h);
		chk.addr = AddrW'(AddrW'(unsigned'(y)) * AddrW'(GridCols) +
			AddrW'(unsigned'(x)));
	end

endmodule

>>> rtl/occupancy_grid_disc_paint_and_check_top.sv
// top level: grid memory, sequencer, configuration registers and result register
// Each word runs alone through a small sequencer around one disc unit and a
// byte grid with one write and one registered read port. Read, write and unused
// opcodes go through the start, read and check steps; paints and the inflated
// query walk every offset of the (2*15+1) x (2*15+1) square one per cycle first
// (a paint whose centre lies off the map skips the walk); clear first writes the
// grid one cell a cycle. After reset the block sweeps all 16384 cells to zero before
// it takes its first word; configuration writes are taken at any time. A finished
// result sits in the output register, so the next word is taken while it waits.
module occupancy_grid_disc_paint_and_check_top import ogdpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [OpW-1:0] op,
	input logic signed [InCoordW-1:0] cell_x,
	input logic signed [InCoordW-1:0] cell_y,
	input logic [ByteW-1:0] write_value,
	input logic [RsqW-1:0] radius_sq,
	output logic out_valid,
	input logic out_stall,
	output logic [ByteW-1:0] cell_value,
	output logic occupied,
	output logic inside_map,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [ByteW-1:0] cfg_data
);

	typedef enum logic [2:0] {
		StBoot,
		StIdle,
		StStart,
		StWalk,
		StClear,
		StFinRd,
		StFinCk
	} state_t;

	localparam logic signed [OffW-1:0] OffMax = OffW'(MaxRad);
	localparam logic signed [OffW-1:0] OffMin = -OffMax;
	localparam logic [AddrW-1:0] AddrLast = AddrW'(GridDepth - 1);

	state_t state_q;
	op_t op_q;
	logic signed [InCoordW-1:0] cx_q;
	logic signed [InCoordW-1:0] cy_q;
	logic [ByteW-1:0] wval_q;
	logic [RsqW-1:0] rsq_q;
	logic signed [OffW-1:0] dx_q;
	logic signed [OffW-1:0] dy_q;
	logic [AddrW-1:0] clr_cnt_q;
	logic check_s1;
	logic hit_q;

	logic [ByteW-1:0] cols_q;
	logic [ByteW-1:0] rows_q;
	logic [ByteW-1:0] free_q;
	logic [ByteW-1:0] occ_q;

	logic out_valid_q;
	logic [ByteW-1:0] cell_value_q;
	logic occupied_q;
	logic inside_q;

	logic [ByteW-1:0] mem [GridDepth];
	logic [ByteW-1:0] rd_data_q;
	logic mem_we;
	logic [AddrW-1:0] mem_wa;
	logic [ByteW-1:0] mem_wd;

	cell_chk_t chk;
	logic is_paint;
	logic walk_end;
	logic out_free;

	// disc unit shared by every step
	ogdpc_disc_unit u_disc (
		.cx(cx_q),
		.cy(cy_q),
		.dx(dx_q),
		.dy(dy_q),
		.rsq(rsq_q),
		.cols(cols_q),
		.rows(rows_q),
		.chk(chk)
	);

	assign is_paint = (op_q == OpPaintOcc) || (op_q == OpPaintFree);
	assign walk_end = (dx_q == OffMax) && (dy_q == OffMax);
	assign out_free = !out_valid_q || !out_stall;

	// handshake outputs
	assign in_stall = (state_q != StIdle);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign cell_value = cell_value_q;
	assign occupied = occupied_q;
	assign inside_map = inside_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= ByteW'(128);
			rows_q <= ByteW'(128);
			free_q <= '0;
			occ_q <= ByteW'(100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CfgCols: cols_q <= cfg_data;
				CfgRows: rows_q <= cfg_data;
				CfgFree: free_q <= cfg_data;
				CfgOcc: occ_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// memory write port select
	always_comb begin
		mem_we = 1'b0;
		mem_wa = chk.addr;
		mem_wd = wval_q;
		unique case (state_q)
			StBoot: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				mem_wd = '0;
			end
			StClear: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				mem_wd = free_q;
			end
			StStart: begin
				mem_we = (op_q == OpWrite) && chk.in_map;
			end
			StWalk: begin
				mem_we = is_paint && chk.in_disc && chk.in_map;
				mem_wd = (op_q == OpPaintOcc) ? occ_q : free_q;
			end
			default: ;
		endcase
	end

	// grid memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[chk.addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StBoot;
			clr_cnt_q <= '0;
			check_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			op_q <= OpRead;
			cx_q <= '0;
			cy_q <= '0;
			wval_q <= '0;
			rsq_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			hit_q <= 1'b0;
			cell_value_q <= '0;
			occupied_q <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != StFinCk)) begin
				out_valid_q <= 1'b0;
			end
			check_s1 <= (state_q == StWalk) && (op_q == OpQuery) &&
				chk.in_disc && chk.in_map;
			if (check_s1 && (rd_data_q >= OccThreshold)) begin
				hit_q <= 1'b1;
			end
			unique case (state_q)
				StBoot: begin
					if (clr_cnt_q == AddrLast) begin
						clr_cnt_q <= '0;
						state_q <= StIdle;
					end else begin
						clr_cnt_q <= clr_cnt_q + AddrW'(1);
					end
				end
				StIdle: begin
					if (in_valid) begin
						op_q <= op_t'(op);
						cx_q <= cell_x;
						cy_q <= cell_y;
						wval_q <= write_value;
						rsq_q <= (radius_sq > RsqMax) ? RsqMax : radius_sq;
						dx_q <= '0;
						dy_q <= '0;
						state_q <= StStart;
					end
				end
				StStart: begin
					hit_q <= 1'b0;
					priority if (op_q == OpQuery || (is_paint && chk.in_map)) begin
						dx_q <= OffMin;
						dy_q <= OffMin;
						state_q <= StWalk;
					end else if (op_q == OpClear) begin
						clr_cnt_q <= '0;
						state_q <= StClear;
					end else begin
						state_q <= StFinRd;
					end
				end
				StWalk: begin
					priority if (walk_end) begin
						dx_q <= '0;
						dy_q <= '0;
						state_q <= StFinRd;
					end else if (dx_q == OffMax) begin
						dx_q <= OffMin;
						dy_q <= dy_q + OffW'(1);
					end else begin
						dx_q <= dx_q + OffW'(1);
					end
				end
				StClear: begin
					if (clr_cnt_q == AddrLast) begin
						clr_cnt_q <= '0;
						state_q <= StFinRd;
					end else begin
						clr_cnt_q <= clr_cnt_q + AddrW'(1);
					end
				end
				StFinRd: begin
					state_q <= StFinCk;
				end
				StFinCk: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						inside_q <= chk.in_map;
						cell_value_q <= chk.in_map ? rd_data_q : free_q;
						occupied_q <= (op_q == OpQuery) ? hit_q :
							(chk.in_map && (rd_data_q >= OccThreshold));
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// no grid write while waiting for a word
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StIdle) |-> !mem_we)
		else $error("grid written while idle");

	// walk offsets stay inside the bounding square
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StWalk) |-> (dx_q >= OffMin && dx_q <= OffMax &&
		dy_q >= OffMin && dy_q <= OffMax))
		else $error("walk offset out of range");

	// a result appears only after the final check step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == StFinCk))
		else $error("result loaded outside final step");

	// query checks only follow walk steps
	assert property (@(posedge clk) disable iff (!arst_n)
		check_s1 |-> $past(state_q == StWalk))
		else $error("cell check outside walk");

endmodule
